@@ hw/rtl/rk4i_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4i_pkg - shared types and constants of the RK4 state integrator
// Fixed point format, field widths, action and direction codes, and the
// beat structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package rk4i_pkg;

   // Fixed point and field widths
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 31;
   localparam int SLOPE_W    = 32;
   localparam int STEP_W     = 21;
   localparam int DB_W       = 16;
   localparam int CNT_W      = 16;
   localparam int NUM_STAGES = 4;
   localparam int STAGE_W    = $clog2(NUM_STAGES);

   // Weighted slope sum k0 + 2k1 + 2k2 + k3 and its product with the step
   localparam int WSUM_W = SLOPE_W + 3;
   localparam int PROD_W = WSUM_W + STEP_W;
   // Product scaled down by the fraction bits
   localparam int ADJ_W  = PROD_W - FRAC_BITS;
   // Product scaled down by 2^(FRAC_BITS+1), before the divide by three
   localparam int QT_W   = PROD_W - FRAC_BITS - 1;
   localparam int QU_W   = QT_W + 1;
   // Halves of the biased dividend; even width so that 2^HALF_W mod 3 is 1
   localparam int HALF_W = ((QU_W + 3) / 4) * 2;
   localparam int QSUM_W = 2 * HALF_W;
   localparam int RECIP_W = HALF_W + 1;
   localparam int PH_W   = HALF_W + RECIP_W;

   // Reciprocal of three for a HALF_W bit dividend, exact after the shift
   localparam logic [RECIP_W-1:0] RECIP3 =
      RECIP_W'(((64'd1 << (HALF_W + 2)) + 64'd2) / 64'd3);
   // (2^HALF_W - 1) / 3, exact since HALF_W is even
   localparam logic [QSUM_W-1:0] THIRD_HALF =
      QSUM_W'(((64'd1 << HALF_W) - 64'd1) / 64'd3);
   // Bias that makes the dividend positive, a multiple of three
   localparam logic [QU_W-1:0] DIV_BIAS = QU_W'(3) << (QT_W - 1);
   // Bias divided by three, removed again from the quotient
   localparam logic [QSUM_W-1:0] DIV_OFFSET = QSUM_W'(1) << (QT_W - 1);

   localparam logic [VAL_W-1:0]  VAL_MAX = {VAL_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W - 1){1'b1}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W - 1){1'b0}}};

   // Register reset values
   localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(655);
   localparam logic [VAL_W-1:0]  INIT_RESET     = VAL_W'(327680);
   localparam logic [DB_W-1:0]   DEADBAND_RESET = DB_W'(7);

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_APPROX = 2'd1,
      ACT_COMMIT = 2'd2,
      ACT_RESET  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_RISE = 2'd1,
      DIR_FALL = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      EXT_NONE = 2'd0,
      EXT_MIN  = 2'd1,
      EXT_MAX  = 2'd2
   } ext_kind_type;

   typedef enum logic [1:0] {
      CSR_STEP_SIZE     = 2'd0,
      CSR_INITIAL_VALUE = 2'd1,
      CSR_DEADBAND      = 2'd2
   } csr_index_type;

   // Accepted request beat
   typedef struct packed {
      action_type                  action;
      logic [STAGE_W-1:0]          stage;
      logic signed [SLOPE_W-1:0]   slope;
   } req_beat_type;

   // Slope times step, leaving the slope stage
   typedef struct packed {
      action_type                  action;
      logic                        full_step;
      logic signed [PROD_W-1:0]    prod;
   } prod_beat_type;

   // Value adjustment, leaving the scale stage
   typedef struct packed {
      action_type                  action;
      logic signed [ADJ_W-1:0]     adj;
   } adj_beat_type;

   // Result beat
   typedef struct packed {
      logic [VAL_W-1:0]            value;
      ext_kind_type                kind;
      logic [VAL_W-1:0]            ext_value;
      logic [CNT_W-1:0]            count;
   } rsp_beat_type;

endpackage

@@ hw/rtl/rk4i_slope_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4i_slope_stage - stage slope accumulators and step multiply
// Holds the four saturating slope accumulators, forms the weighted sum and
// multiplies the selected slope or sum by the step size.
// ----------------------------------------------------------------------------
module rk4i_slope_stage
   import rk4i_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  req_beat_type        in_beat,
   input  logic [STEP_W-1:0]   step_size,
   output logic                out_valid,
   input  logic                out_ready,
   output prod_beat_type       out_beat
);

   logic signed [SLOPE_W-1:0]        slopes_ff [NUM_STAGES];
   logic signed [SLOPE_W-1:0]        slopes_in [NUM_STAGES];
   logic                             out_valid_ff;
   prod_beat_type                    out_beat_ff;
   prod_beat_type                    out_beat_in;
   logic                             load;
   logic signed [WSUM_W-1:0]         wsum;
   logic signed [WSUM_W-1:0]         oper;
   logic signed [WSUM_W+STEP_W:0]    prod_full;

   function automatic logic signed [SLOPE_W-1:0] sat_add(
      input logic signed [SLOPE_W-1:0] a,
      input logic signed [SLOPE_W-1:0] b
   );
      logic [SLOPE_W:0] s;
      s = {a[SLOPE_W-1], a} + {b[SLOPE_W-1], b};
      if (s[SLOPE_W] != s[SLOPE_W-1]) begin
         return s[SLOPE_W] ? SLOPE_MIN : SLOPE_MAX;
      end
      return s[SLOPE_W-1:0];
   endfunction

   // Advance when the product register is empty or drains
   assign in_ready  = !out_valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

   // Update the accumulators: add into one, clear all on commit or reset
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         slopes_in[i] = slopes_ff[i];
         if (load) begin
            case (in_beat.action) inside
               ACT_ADD: begin
                  if (in_beat.stage == STAGE_W'(i)) begin
                     slopes_in[i] = sat_add(slopes_ff[i], in_beat.slope);
                  end
               end
               ACT_COMMIT, ACT_RESET: slopes_in[i] = '0;
               default: ;
            endcase
         end
      end
   end

   // Weighted slope sum for the commit
   assign wsum = WSUM_W'(slopes_ff[0]) + (WSUM_W'(slopes_ff[1]) <<< 1)
               + (WSUM_W'(slopes_ff[2]) <<< 1) + WSUM_W'(slopes_ff[3]);

   // Pick the multiplicand: previous stage slope or the weighted sum
   always_comb begin
      oper = '0;
      case (in_beat.action)
         ACT_APPROX: begin
            case (in_beat.stage)
               2'd1:    oper = WSUM_W'(slopes_ff[0]);
               2'd2:    oper = WSUM_W'(slopes_ff[1]);
               2'd3:    oper = WSUM_W'(slopes_ff[2]);
               default: oper = '0;
            endcase
         end
         ACT_COMMIT: oper = wsum;
         default:    oper = '0;
      endcase
   end

   assign prod_full = oper * signed'({1'b0, step_size});

   always_comb begin
      out_beat_in.action    = in_beat.action;
      out_beat_in.full_step = (in_beat.action == ACT_APPROX)
                            && (in_beat.stage == STAGE_W'(NUM_STAGES - 1));
      out_beat_in.prod      = prod_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STAGES; i++) begin
            slopes_ff[i] <= '0;
         end
      end else begin
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         slopes_ff <= slopes_in;
      end
      if (load) begin
         out_beat_ff <= out_beat_in;
      end
   end

endmodule

@@ hw/rtl/rk4i_scale_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4i_scale_stage - fixed point scaling and divide by six
// Floors the product to the value scale. For a commit the product is
// divided by 2^(FRAC_BITS+1) and then by three through two registered
// reciprocal multiplies on the halves of a biased dividend.
// ----------------------------------------------------------------------------
module rk4i_scale_stage
   import rk4i_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  prod_beat_type       in_beat,
   output logic                out_valid,
   input  logic                out_ready,
   output adj_beat_type        out_beat
);

   // Divider stage registers
   logic                        div_valid_ff;
   action_type                  div_action_ff;
   logic signed [ADJ_W-1:0]     div_approx_ff;
   logic [PH_W-1:0]             div_ph_ff;
   logic [PH_W-1:0]             div_pl_ff;
   logic [1:0]                  div_uh_lo_ff;
   logic [1:0]                  div_ul_lo_ff;
   logic                        div_ready;
   logic                        load;

   // Output stage registers
   logic                        out_valid_ff;
   adj_beat_type                out_beat_ff;
   adj_beat_type                out_beat_in;
   logic                        div_move;

   logic signed [QT_W-1:0]      quot_t;
   logic [QU_W-1:0]             div_u;
   logic [QSUM_W-1:0]           div_u_pad;
   logic [HALF_W-1:0]           div_uh;
   logic [HALF_W-1:0]           div_ul;
   logic signed [ADJ_W-1:0]     approx_adj;

   logic [HALF_W-2:0]           third_h;
   logic [HALF_W-2:0]           third_l;
   logic [1:0]                  rem_h;
   logic [1:0]                  rem_l;
   logic [2:0]                  rem_sum;
   logic [QSUM_W-1:0]           rem_part;
   logic [QSUM_W-1:0]           quot_u;
   logic signed [QSUM_W-1:0]    delta;

   assign div_ready = !out_valid_ff || out_ready;
   assign in_ready  = !div_valid_ff || div_ready;
   assign load      = in_valid && in_ready;
   assign div_move  = div_valid_ff && div_ready;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

   // Floor the product for a stage estimate: half step or full step
   assign approx_adj = in_beat.full_step ? in_beat.prod[PROD_W-1:FRAC_BITS]
                     : {in_beat.prod[PROD_W-1], in_beat.prod[PROD_W-1:FRAC_BITS+1]};

   // Bias the floored product positive and split it into halves
   assign quot_t    = in_beat.prod[PROD_W-1:FRAC_BITS+1];
   assign div_u     = QU_W'(quot_t) + DIV_BIAS;
   assign div_u_pad = QSUM_W'(div_u);
   assign div_uh    = div_u_pad[QSUM_W-1:HALF_W];
   assign div_ul    = div_u_pad[HALF_W-1:0];

   // Hold the divider partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= 1'b0;
      end else if (in_ready) begin
         div_valid_ff <= in_valid;
      end
      if (load) begin
         div_action_ff <= in_beat.action;
         div_approx_ff <= approx_adj;
         div_ph_ff     <= PH_W'(div_uh) * PH_W'(RECIP3);
         div_pl_ff     <= PH_W'(div_ul) * PH_W'(RECIP3);
         div_uh_lo_ff  <= div_uh[1:0];
         div_ul_lo_ff  <= div_ul[1:0];
      end
   end

   // Quotient of each half and the remainders left over
   assign third_h = div_ph_ff[PH_W-1:HALF_W+2];
   assign third_l = div_pl_ff[PH_W-1:HALF_W+2];
   // x - 3q modulo 4 equals x + q modulo 4
   assign rem_h   = div_uh_lo_ff + third_h[1:0];
   assign rem_l   = div_ul_lo_ff + third_l[1:0];
   assign rem_sum = {1'b0, rem_h} + {1'b0, rem_l};

   always_comb begin
      case (rem_h)
         2'd1:    rem_part = THIRD_HALF;
         2'd2:    rem_part = THIRD_HALF << 1;
         default: rem_part = '0;
      endcase
   end

   // Recombine: u/3 = qh*2^H + ql + rh*(2^H-1)/3 + (rh+rl)/3
   assign quot_u = (QSUM_W'(third_h) << HALF_W) + QSUM_W'(third_l) + rem_part
                 + QSUM_W'(rem_sum >= 3'd3);
   assign delta  = quot_u - DIV_OFFSET;

   always_comb begin
      out_beat_in.action = div_action_ff;
      if (div_action_ff == ACT_COMMIT) begin
         out_beat_in.adj = ADJ_W'(delta);
      end else begin
         out_beat_in.adj = div_approx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (div_ready) begin
         out_valid_ff <= div_valid_ff;
      end
      if (div_move) begin
         out_beat_ff <= out_beat_in;
      end
   end

endmodule

@@ hw/rtl/rk4i_value_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4i_value_stage - current value, extremum detection and result register
// Applies the adjustment to the current value with clamping, tracks the
// direction of change past the deadband and counts reversals.
// ----------------------------------------------------------------------------
module rk4i_value_stage
   import rk4i_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  adj_beat_type        in_beat,
   input  logic [VAL_W-1:0]    initial_value,
   input  logic [DB_W-1:0]     deadband,
   output logic                out_valid,
   input  logic                out_ready,
   output rsp_beat_type        out_beat
);

   logic [VAL_W-1:0]          value_ff;
   logic [VAL_W-1:0]          value_in;
   dir_type                   dir_ff;
   dir_type                   dir_in;
   dir_type                   dir_new;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      out_valid_ff;
   rsp_beat_type              out_beat_ff;
   rsp_beat_type              out_beat_in;
   logic                      load;

   logic signed [ADJ_W:0]     vsum;
   logic [VAL_W-1:0]          clamped;
   logic signed [VAL_W:0]     change;
   logic signed [VAL_W:0]     db_s;
   logic                      moved;

   assign in_ready  = !out_valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

   // Add and clamp to the value range
   assign vsum = {{(ADJ_W + 1 - VAL_W){1'b0}}, value_ff} + {in_beat.adj[ADJ_W-1], in_beat.adj};

   always_comb begin
      if (vsum[ADJ_W]) begin
         clamped = '0;
      end else if (|vsum[ADJ_W-1:VAL_W]) begin
         clamped = VAL_MAX;
      end else begin
         clamped = vsum[VAL_W-1:0];
      end
   end

   // Change against the deadband
   assign change  = {1'b0, clamped} - {1'b0, value_ff};
   assign db_s    = (VAL_W + 1)'(deadband);
   assign moved   = (change > db_s) || (change < -db_s);
   assign dir_new = change[VAL_W] ? DIR_FALL : DIR_RISE;

   // Next state and result
   always_comb begin
      value_in              = value_ff;
      dir_in                = dir_ff;
      count_in              = count_ff;
      out_beat_in.value     = value_ff;
      out_beat_in.kind      = EXT_NONE;
      out_beat_in.ext_value = '0;
      if (load) begin
         case (in_beat.action)
            ACT_APPROX: out_beat_in.value = clamped;
            ACT_COMMIT: begin
               value_in          = clamped;
               out_beat_in.value = clamped;
               if (moved) begin
                  if (dir_ff == DIR_FALL && dir_new == DIR_RISE) begin
                     out_beat_in.kind      = EXT_MIN;
                     out_beat_in.ext_value = value_ff;
                  end else if (dir_ff == DIR_RISE && dir_new == DIR_FALL) begin
                     out_beat_in.kind      = EXT_MAX;
                     out_beat_in.ext_value = value_ff;
                  end
                  if (out_beat_in.kind != EXT_NONE && count_ff != CNT_MAX) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  dir_in = dir_new;
               end
            end
            ACT_RESET: begin
               value_in          = initial_value;
               dir_in            = DIR_NONE;
               count_in          = '0;
               out_beat_in.value = initial_value;
            end
            default: ;
         endcase
      end
      out_beat_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         value_ff     <= INIT_RESET;
         dir_ff       <= DIR_NONE;
         count_ff     <= '0;
      end else begin
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         value_ff <= value_in;
         dir_ff   <= dir_in;
         count_ff <= count_in;
      end
      if (load) begin
         out_beat_ff <= out_beat_in;
      end
   end

   // A reported extremum has been counted
   a_ext_counted: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_beat_ff.kind != EXT_NONE |-> out_beat_ff.count != '0)
      else $error("extremum reported with zero reversal count");

   // Only a reset action lowers the count
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      load && in_beat.action != ACT_RESET |=> count_ff >= $past(count_ff))
      else $error("reversal count dropped without reset action");

   // A maximum leaves the value falling, a minimum leaves it rising
   a_max_dir: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_beat_ff.kind == EXT_MAX |-> dir_ff == DIR_FALL)
      else $error("maximum reported but direction is not falling");

   a_min_dir: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_beat_ff.kind == EXT_MIN |-> dir_ff == DIR_RISE)
      else $error("minimum reported but direction is not rising");

   // No extremum means no extremum value
   a_ext_value_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_beat_ff.kind == EXT_NONE |-> out_beat_ff.ext_value == '0)
      else $error("extremum value set without an extremum");

endmodule

@@ hw/rtl/rk4_state_integrator_with_extrema_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4_state_integrator_with_extrema_core - RK4 integrator with extremum watch
// Top level: request register, configuration registers and the stage chain.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while no stall backs up from the
// result side, and each gives exactly one result. The beat passes the
// request register, the slope stage (accumulators and the 35x21 step
// multiply), two scale stages (floor and a divide by six built from two
// registered reciprocal multiplies) and the value stage, whose output
// register holds the result. Slope accumulators live in the slope
// stage and the current value, direction and reversal count in the value
// stage, so items that follow one another need no stall. A full pipeline
// keeps accepting while its result waits, until every stage holds an item.
// There is no clearing pass after reset. Write configuration only while
// the block is idle; a new initial value takes effect at the next reset
// action.
// ----------------------------------------------------------------------------
module rk4_state_integrator_with_extrema_core
   import rk4i_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   // Request beat
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [31:0] slope
   input  logic [3:0]          req_tuser,   // [1:0] action, [3:2] stage

   // Result beat
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata,   // [30:0] value, [61:31] extremum_value,
                                            // [77:62] reversal_count, [79:78] zero
   output logic [1:0]          rsp_tuser,   // [1:0] extremum_kind

   // Configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [VAL_W-1:0]    csr_data
);

   logic                 req_valid_ff;
   req_beat_type         req_beat_ff;
   req_beat_type         req_beat_in;
   logic                 slope_ready;
   logic                 req_load;

   logic [STEP_W-1:0]    step_size_ff;
   logic [VAL_W-1:0]     initial_value_ff;
   logic [DB_W-1:0]      deadband_ff;

   logic                 prod_valid;
   logic                 prod_ready;
   prod_beat_type        prod_beat;
   logic                 adj_valid;
   logic                 adj_ready;
   adj_beat_type         adj_beat;
   rsp_beat_type         rsp_beat;

   // Request register
   assign req_tready = !req_valid_ff || slope_ready;
   assign req_load   = req_tvalid && req_tready;

   always_comb begin
      req_beat_in.action = action_type'(req_tuser[1:0]);
      req_beat_in.stage  = req_tuser[3:2];
      req_beat_in.slope  = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
      if (req_load) begin
         req_beat_ff <= req_beat_in;
      end
   end

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff     <= STEP_RESET;
         initial_value_ff <= INIT_RESET;
         deadband_ff      <= DEADBAND_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_SIZE:     step_size_ff     <= csr_data[STEP_W-1:0];
            CSR_INITIAL_VALUE: initial_value_ff <= csr_data;
            CSR_DEADBAND:      deadband_ff      <= csr_data[DB_W-1:0];
            default: ;
         endcase
      end
   end

   rk4i_slope_stage u_slope (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid_ff),
      .in_ready   (slope_ready),
      .in_beat    (req_beat_ff),
      .step_size  (step_size_ff),
      .out_valid  (prod_valid),
      .out_ready  (prod_ready),
      .out_beat   (prod_beat)
   );

   rk4i_scale_stage u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prod_valid),
      .in_ready   (prod_ready),
      .in_beat    (prod_beat),
      .out_valid  (adj_valid),
      .out_ready  (adj_ready),
      .out_beat   (adj_beat)
   );

   rk4i_value_stage u_value (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (adj_valid),
      .in_ready      (adj_ready),
      .in_beat       (adj_beat),
      .initial_value (initial_value_ff),
      .deadband      (deadband_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_beat      (rsp_beat)
   );

   // Pack the result beat
   assign rsp_tdata = {2'b00, rsp_beat.count, rsp_beat.ext_value, rsp_beat.value};
   assign rsp_tuser = rsp_beat.kind;

endmodule

@@ verif/tb_rk4_state_integrator_with_extrema_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rk4_state_integrator_with_extrema_core - self-checking bench of the core
// Drives request beats (directed corner cases, then RK4 step sequences mixed
// with noise) under several register settings. A scoreboard class computes
// each expected result beat from its own copy of the integrator state and
// compares every result beat field by field. The bench ends with a run of
// commits that reverse direction on every step.
// ----------------------------------------------------------------------------
module tb_rk4_state_integrator_with_extrema_core;
   import rk4i_pkg::*;

   // Predicts result beats and compares them with what the core returns
   class rk4_scoreboard;
      logic [STEP_W-1:0]         step_size;
      logic [VAL_W-1:0]          initial_value;
      logic [DB_W-1:0]           deadband;
      logic [VAL_W-1:0]          cur_value;
      logic signed [SLOPE_W-1:0] slopes [NUM_STAGES];
      dir_type                   last_dir;
      logic [CNT_W-1:0]          reversals;
      rsp_beat_type              pending_rsp [$];
      int                        errors;
      int                        checked;
      int                        extrema_seen;

      function new();
         step_size     = STEP_RESET;
         initial_value = INIT_RESET;
         deadband      = DEADBAND_RESET;
         cur_value     = INIT_RESET;
         foreach (slopes[i]) slopes[i] = '0;
         last_dir      = DIR_NONE;
         reversals     = '0;
         errors        = 0;
         checked       = 0;
         extrema_seen  = 0;
      endfunction

      function automatic logic [VAL_W-1:0] clamp_val(longint v);
         if (v < 0) return '0;
         if (v > longint'(VAL_MAX)) return VAL_MAX;
         return v[VAL_W-1:0];
      endfunction

      function automatic logic signed [SLOPE_W-1:0] sat_slope(longint v);
         if (v > longint'(SLOPE_MAX)) return SLOPE_MAX;
         if (v < longint'(SLOPE_MIN)) return SLOPE_MIN;
         return v[SLOPE_W-1:0];
      endfunction

      // Floor of p / (6 * 2^FRAC_BITS)
      function automatic longint floor_div6(longint p);
         longint d;
         longint q;
         d = longint'(6) << FRAC_BITS;
         q = p / d;
         if (p < 0 && q * d != p) q = q - 1;
         return q;
      endfunction

      function void set_register(csr_index_type idx, logic [VAL_W-1:0] data);
         case (idx)
            CSR_STEP_SIZE:     step_size     = data[STEP_W-1:0];
            CSR_INITIAL_VALUE: initial_value = data;
            CSR_DEADBAND:      deadband      = data[DB_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the integrator on one accepted request beat
      function void note_request(action_type act, logic [STAGE_W-1:0] stage,
                                 logic signed [SLOPE_W-1:0] slope);
         rsp_beat_type     e;
         longint           adj;
         longint           wsum;
         longint           change;
         longint           db;
         logic [VAL_W-1:0] old;
         dir_type          dir;
         e = '0;
         e.kind = EXT_NONE;
         e.value = cur_value;
         db = longint'(deadband);
         case (act)
            ACT_ADD: begin
               slopes[stage] = sat_slope(longint'(slopes[stage]) + longint'(slope));
            end
            ACT_APPROX: begin
               case (stage)
                  2'd1: adj = (longint'(slopes[0]) * longint'(step_size)) >>> (FRAC_BITS + 1);
                  2'd2: adj = (longint'(slopes[1]) * longint'(step_size)) >>> (FRAC_BITS + 1);
                  2'd3: adj = (longint'(slopes[2]) * longint'(step_size)) >>> FRAC_BITS;
                  default: adj = 0;
               endcase
               e.value = clamp_val(longint'(cur_value) + adj);
            end
            ACT_COMMIT: begin
               wsum = longint'(slopes[0]) + 2 * longint'(slopes[1])
                    + 2 * longint'(slopes[2]) + longint'(slopes[3]);
               old = cur_value;
               cur_value = clamp_val(longint'(old) + floor_div6(wsum * longint'(step_size)));
               foreach (slopes[i]) slopes[i] = '0;
               change = longint'(cur_value) - longint'(old);
               if (change > db || change < -db) begin
                  dir = (change > 0) ? DIR_RISE : DIR_FALL;
                  if (last_dir == DIR_FALL && dir == DIR_RISE) begin
                     e.kind = EXT_MIN;
                     e.ext_value = old;
                  end else if (last_dir == DIR_RISE && dir == DIR_FALL) begin
                     e.kind = EXT_MAX;
                     e.ext_value = old;
                  end
                  if (e.kind != EXT_NONE && reversals != CNT_MAX) reversals = reversals + 1'b1;
                  last_dir = dir;
               end
               e.value = cur_value;
            end
            default: begin
               cur_value = initial_value;
               foreach (slopes[i]) slopes[i] = '0;
               last_dir = DIR_NONE;
               reversals = '0;
               e.value = cur_value;
            end
         endcase
         e.count = reversals;
         pending_rsp = {pending_rsp, e};
      endfunction

      // Compare one result beat with the oldest prediction
      function void check_result(rsp_beat_type got);
         rsp_beat_type e;
         if (pending_rsp.size() == 0) begin
            $error("result beat with no prediction pending");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         checked++;
         if (e.kind != EXT_NONE) extrema_seen++;
         if (got.value !== e.value) begin
            $error("value: expected %0d, actual %0d", e.value, got.value);
            errors++;
         end
         if (got.kind !== e.kind) begin
            $error("extremum_kind: expected %0d, actual %0d", e.kind, got.kind);
            errors++;
         end
         if (got.ext_value !== e.ext_value) begin
            $error("extremum_value: expected %0d, actual %0d", e.ext_value, got.ext_value);
            errors++;
         end
         if (got.count !== e.count) begin
            $error("reversal_count: expected %0d, actual %0d", e.count, got.count);
            errors++;
         end
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function void check_drained();
         if (pending_rsp.size() != 0) begin
            $error("%0d predicted result beats never arrived", pending_rsp.size());
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata = '0;   // [31:0] slope
   logic [3:0]         req_tuser = '0;   // [1:0] action, [3:2] stage
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [79:0]        rsp_tdata;        // [30:0] value, [61:31] extremum_value,
                                         // [77:62] reversal_count, [79:78] zero
   logic [1:0]         rsp_tuser;        // [1:0] extremum_kind
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [VAL_W-1:0]   csr_data = '0;

   rk4_scoreboard      sb;
   rsp_beat_type       rsp_seen;
   int                 n_sent = 0;
   int                 n_settings = 0;
   int                 hold_left = 0;
   bit                 idle_on = 1'b0;
   int                 hold_asks = 0;
   int                 hold_done = 0;

   rk4_state_integrator_with_extrema_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Slope magnitudes from inside the deadband up to the full range
   function automatic logic signed [SLOPE_W-1:0] rand_slope();
      int unsigned               r;
      logic signed [SLOPE_W-1:0] mag;
      r = $urandom_range(0, 9);
      if (r < 4) mag = $urandom_range(0, 4000);
      else if (r < 7) mag = $urandom_range(0, 1 << 22);
      else if (r < 9) return $urandom;
      else begin
         case ($urandom_range(0, 3))
            0: return SLOPE_MAX;
            1: return SLOPE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   // Offer one request beat, hold it until accepted, then maybe idle
   task automatic send_req(action_type act, logic [STAGE_W-1:0] stage,
                           logic signed [SLOPE_W-1:0] slope);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= slope;
      req_tuser  <= {stage, act};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, stage, slope);
      n_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted beat has returned
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all three registers in a row; call only while idle
   task automatic write_settings(logic [STEP_W-1:0] step, logic [VAL_W-1:0] init,
                                 logic [DB_W-1:0] db);
      logic [VAL_W-1:0] vals [3];
      csr_index_type    idx;
      vals[0] = VAL_W'(step);
      vals[1] = init;
      vals[2] = VAL_W'(db);
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_register(idx, vals[i]);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // One RK4 step: per stage one or two slope adds, each stage after the first with an optional estimate
   task automatic run_sequence();
      logic signed [SLOPE_W-1:0] base;
      base = rand_slope();
      for (int st = 0; st < NUM_STAGES; st++) begin
         if (st > 0 && $urandom_range(0, 3) != 0)
            send_req(ACT_APPROX, STAGE_W'(st), $urandom);
         repeat ($urandom_range(1, 2))
            send_req(ACT_ADD, STAGE_W'(st), ($urandom_range(0, 3) == 0) ? rand_slope() : base);
      end
      if ($urandom_range(0, 3) == 0) send_req(ACT_APPROX, '0, $urandom);
      send_req(ACT_COMMIT, STAGE_W'($urandom_range(0, 3)), $urandom);
   endtask

   // Mostly well-formed steps, some resets and noise beats
   task automatic run_random(int count);
      int start;
      int r;
      start = n_sent;
      while (n_sent - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 6)
            send_req(ACT_RESET, STAGE_W'($urandom_range(0, 3)), $urandom);
         else if (r < 25)
            send_req(action_type'($urandom_range(0, 3)), STAGE_W'($urandom_range(0, 3)),
                     rand_slope());
         else
            run_sequence();
      end
   endtask

   // Sample result beats and pace the receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen.value     = rsp_tdata[30:0];
            rsp_seen.ext_value = rsp_tdata[61:31];
            rsp_seen.count     = rsp_tdata[77:62];
            rsp_seen.kind      = ext_kind_type'(rsp_tuser);
            sb.check_result(rsp_seen);
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_asks != hold_done) begin
            // long hold-off so the pipeline fills and stalls the input
            hold_done = hold_done + 1;
            hold_left = 79;
            rsp_tready <= 1'b0;
         end else begin
            hold_left = pick_gap();
            if (hold_left > 0) begin
               hold_left = hold_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #8ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int guard;
      logic [STEP_W-1:0] step;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: estimates, saturating adds, reversals, deadband, clamp at zero
      idle_on = 1'b0;
      for (int st = 0; st < NUM_STAGES; st++) send_req(ACT_APPROX, STAGE_W'(st), '0);
      send_req(ACT_ADD, 2'd0, SLOPE_MAX);
      send_req(ACT_ADD, 2'd0, 32'sd1);
      send_req(ACT_ADD, 2'd1, SLOPE_MIN);
      send_req(ACT_ADD, 2'd1, -32'sd1);
      send_req(ACT_ADD, 2'd2, SLOPE_MAX);
      send_req(ACT_ADD, 2'd3, -32'sd12345);
      for (int st = 1; st < NUM_STAGES; st++) send_req(ACT_APPROX, STAGE_W'(st), '1);
      send_req(ACT_COMMIT, 2'd0, '0);
      send_req(ACT_ADD, 2'd0, -32'sd600000);
      send_req(ACT_COMMIT, 2'd1, '0);
      send_req(ACT_ADD, 2'd3, 32'sd600000);
      send_req(ACT_COMMIT, 2'd2, '0);
      send_req(ACT_ADD, 2'd0, 32'sd2000);
      send_req(ACT_COMMIT, 2'd3, '1);
      send_req(ACT_ADD, 2'd1, SLOPE_MIN);
      send_req(ACT_ADD, 2'd2, SLOPE_MIN);
      send_req(ACT_COMMIT, 2'd0, '0);
      send_req(ACT_RESET, 2'd2, SLOPE_MIN);

      // Step of 16.0, largest initial value, no deadband: clamp at the top
      wait_idle();
      write_settings(STEP_W'(1048576), VAL_MAX, '0);
      send_req(ACT_RESET, 2'd0, '0);
      send_req(ACT_ADD, 2'd0, SLOPE_MAX);
      send_req(ACT_APPROX, 2'd1, '0);
      send_req(ACT_ADD, 2'd2, SLOPE_MAX);
      send_req(ACT_APPROX, 2'd3, '0);
      send_req(ACT_COMMIT, 2'd0, '0);
      send_req(ACT_ADD, 2'd0, SLOPE_MIN);
      send_req(ACT_COMMIT, 2'd0, '0);
      idle_on = 1'b1;
      run_random(150);

      // Smallest nonzero step, zero initial value, widest deadband, with back-pressure
      wait_idle();
      write_settings(STEP_W'(1), '0, '1);
      send_req(ACT_RESET, 2'd1, '0);
      run_random(100);
      hold_asks = hold_asks + 1;
      run_random(60);
      wait_idle();
      run_random(60);

      // Random settings, zero and all-ones step among them
      for (int k = 0; k < 3; k++) begin
         wait_idle();
         case (k)
            0: step = '0;
            1: step = '1;
            default: step = STEP_W'($urandom_range(1, 1048576));
         endcase
         write_settings(step, VAL_W'($urandom), DB_W'($urandom_range(0, 64)));
         send_req(ACT_RESET, STAGE_W'($urandom_range(0, 3)), $urandom);
         run_random(100);
      end

      // Back to the reset values, full rate on both sides
      wait_idle();
      idle_on = 1'b0;
      write_settings(STEP_RESET, INIT_RESET, DEADBAND_RESET);
      send_req(ACT_RESET, 2'd3, '0);
      run_random(120);

      // Step of exactly 6.0 makes each commit move by the slope: alternate
      // up and down so that every commit after the first is a reversal
      wait_idle();
      write_settings(STEP_W'(6 << FRAC_BITS), INIT_RESET, '0);
      send_req(ACT_RESET, 2'd0, '0);
      repeat (10) begin
         send_req(ACT_ADD, 2'd0, 32'sd1000);
         send_req(ACT_COMMIT, 2'd0, '0);
         send_req(ACT_ADD, 2'd0, -32'sd1000);
         send_req(ACT_COMMIT, 2'd0, '0);
      end
      send_req(ACT_RESET, 2'd0, '0);

      // Drain and settle
      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.pending() > 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      sb.check_drained();

      $display("Sent %0d request beats under %0d register settings plus the reset values.",
               n_sent, n_settings);
      $display("Checked %0d result beats, %0d of them reporting a minimum or maximum.",
               sb.checked, sb.extrema_seen);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/rk4i_pkg.sv
hw/rtl/rk4i_slope_stage.sv
hw/rtl/rk4i_scale_stage.sv
hw/rtl/rk4i_value_stage.sv
hw/rtl/rk4_state_integrator_with_extrema_core.sv
verif/tb_rk4_state_integrator_with_extrema_core.sv
